// ===== hdl/phx_pkg.sv =====
// ----------------------------------------------------------------------------
// phx_pkg
// Shared widths, constants and codes of the point to hex cell quantizer.
// ----------------------------------------------------------------------------
package phx_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int INDEX_WIDTH = 8;
    localparam int UNIT_WIDTH  = 16;
    localparam int FRAC_BITS   = 34;

    // projection: x*cos30 + y/2 in Q.22, one growth bit for the sum
    localparam int PROJ_W  = COORD_WIDTH + 15;
    // projection times the reciprocal unit, Q.34
    localparam int PROD_W  = PROJ_W + UNIT_WIDTH;
    // rounded axis value, residual, sum and corrected value
    localparam int RI_W    = PROD_W - FRAC_BITS + 2;
    localparam int RES_W   = FRAC_BITS;
    localparam int SUM_W   = RI_W + 2;
    localparam int COR_W   = RI_W + 3;

    localparam int COS30_Q14  = 14189;
    localparam int HALF_SHIFT = 13;
    localparam int ONE_SHIFT  = 14;

    localparam logic [UNIT_WIDTH-1:0] UNIT_RESET = UNIT_WIDTH'(4096);

    localparam int N_STAGES = 5;

    localparam logic [1:0] AX_I = 2'd0;
    localparam logic [1:0] AX_J = 2'd1;
    localparam logic [1:0] AX_K = 2'd2;

endpackage

// ===== hdl/point_to_hex_cell_quantizer_top.sv =====
// ----------------------------------------------------------------------------
// point_to_hex_cell_quantizer_top
// Maps a Q8.8 camera plane point to its hex cell in cube coordinates.
//
//   channel   dir  payload                                   handshake
//   s_axis    in   tdata: point_x, point_y                   tvalid/tready
//   m_axis    out  tdata: cell_i, cell_j, cell_k; tuser: sat tvalid/tready
//   cfg       in   i_cfg_wdata: inverse_cell_unit            i_cfg_we
//
// One point per clock while the output is not stalled, through the stage chain
// (projection, unit multiply, rounding, axis pick, correct and clamp).
// Each stage holds its own valid bit and loads whenever it is empty or the
// next stage moves, so bubbles close up under an output stall.
// Synchronous active-low reset clears the valid bits and sets the unit to 1.0.
// ----------------------------------------------------------------------------
module point_to_hex_cell_quantizer_top
    import phx_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [2*COORD_WIDTH-1:0]   s_axis_tdata,   // point_x, point_y
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [3*INDEX_WIDTH-1:0]   m_axis_tdata,   // cell_i, cell_j, cell_k
    output logic                       m_axis_tuser,   // index_saturated
    input  logic                       i_cfg_we,
    input  logic [UNIT_WIDTH-1:0]      i_cfg_wdata
);

    logic [UNIT_WIDTH-1:0]         r_unit;
    logic [N_STAGES-1:0]           r_v;
    logic [N_STAGES-1:0]           rdy;
    logic [N_STAGES-1:0]           n_v;

    logic signed [PROD_W-1:0]      di, dj, dk;
    logic signed [RI_W-1:0]        ri, rj, rk;
    logic [RES_W-1:0]              ai, aj, ak;
    logic signed [INDEX_WIDTH-1:0] cell_i, cell_j, cell_k;
    logic                          sat;

    always_comb begin
        rdy[N_STAGES-1] = !r_v[N_STAGES-1] || m_axis_tready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
        n_v = r_v;
        for (int k = 0; k < N_STAGES; k++) begin
            if (rdy[k]) begin
                n_v[k] = (k == 0) ? s_axis_tvalid : r_v[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_unit <= UNIT_RESET;
        end else begin
            r_v <= n_v;
            if (i_cfg_we) begin
                r_unit <= i_cfg_wdata;
            end
        end
    end

    phx_proj u_proj (
        .i_clk     (i_clk),
        .i_adv     (rdy[1:0]),
        .i_point_x (s_axis_tdata[COORD_WIDTH-1:0]),
        .i_point_y (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .i_unit    (r_unit),
        .o_di      (di),
        .o_dj      (dj),
        .o_dk      (dk)
    );

    phx_round u_round (
        .i_clk (i_clk),
        .i_adv (rdy[2]),
        .i_di  (di),
        .i_dj  (dj),
        .i_dk  (dk),
        .o_ri  (ri),
        .o_rj  (rj),
        .o_rk  (rk),
        .o_ai  (ai),
        .o_aj  (aj),
        .o_ak  (ak)
    );

    phx_fix u_fix (
        .i_clk    (i_clk),
        .i_adv    (rdy[4:3]),
        .i_ri     (ri),
        .i_rj     (rj),
        .i_rk     (rk),
        .i_ai     (ai),
        .i_aj     (aj),
        .i_ak     (ak),
        .o_cell_i (cell_i),
        .o_cell_j (cell_j),
        .o_cell_k (cell_k),
        .o_sat    (sat)
    );

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = r_v[N_STAGES-1];
    assign m_axis_tdata  = {cell_k, cell_j, cell_i};
    assign m_axis_tuser  = sat;

    localparam logic signed [INDEX_WIDTH-1:0] IDX_MAX = {1'b0, {(INDEX_WIDTH-1){1'b1}}};
    localparam logic signed [INDEX_WIDTH-1:0] IDX_MIN = {1'b1, {(INDEX_WIDTH-1){1'b0}}};

    a_sum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (cell_i + cell_j + cell_k == '0))
        else $error("unclamped cell does not sum to zero");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (cell_i == IDX_MAX || cell_i == IDX_MIN || cell_j == IDX_MAX ||
             cell_j == IDX_MIN || cell_k == IDX_MAX || cell_k == IDX_MIN))
        else $error("saturation flag without a clamped coordinate");

    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

endmodule

// ===== hdl/phx_proj.sv =====
// ----------------------------------------------------------------------------
// phx_proj
// Two stages: cube axis projection of the point, then scaling by the unit.
// ----------------------------------------------------------------------------
module phx_proj
    import phx_pkg::*;
(
    input  logic                          i_clk,
    input  logic [1:0]                    i_adv,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic [UNIT_WIDTH-1:0]         i_unit,
    output logic signed [PROD_W-1:0]      o_di,
    output logic signed [PROD_W-1:0]      o_dj,
    output logic signed [PROD_W-1:0]      o_dk
);

    localparam logic signed [PROJ_W-1:0] COS30 = PROJ_W'(COS30_Q14);

    logic signed [PROJ_W-1:0] x_ext;
    logic signed [PROJ_W-1:0] y_ext;
    logic signed [PROJ_W-1:0] xc;
    logic signed [PROJ_W-1:0] n_pi, n_pj, n_pk;
    logic signed [PROJ_W-1:0] r_pi, r_pj, r_pk;
    logic signed [PROD_W-1:0] u_ext;
    logic signed [PROD_W-1:0] r_di, r_dj, r_dk;

    always_comb begin
        x_ext = PROJ_W'(i_point_x);
        y_ext = PROJ_W'(i_point_y);
        xc    = x_ext * COS30;
        n_pi  = xc + (y_ext <<< HALF_SHIFT);
        n_pj  = (y_ext <<< HALF_SHIFT) - xc;
        n_pk  = -(y_ext <<< ONE_SHIFT);
        u_ext = PROD_W'($signed({1'b0, i_unit}));
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_pi <= n_pi;
            r_pj <= n_pj;
            r_pk <= n_pk;
        end
        if (i_adv[1]) begin
            r_di <= PROD_W'(r_pi) * u_ext;
            r_dj <= PROD_W'(r_pj) * u_ext;
            r_dk <= PROD_W'(r_pk) * u_ext;
        end
    end

    assign o_di = r_di;
    assign o_dj = r_dj;
    assign o_dk = r_dk;

endmodule

// ===== hdl/phx_round.sv =====
// ----------------------------------------------------------------------------
// phx_round
// One stage: rounds each axis half away from zero and keeps its residual.
// ----------------------------------------------------------------------------
module phx_round
    import phx_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_adv,
    input  logic signed [PROD_W-1:0] i_di,
    input  logic signed [PROD_W-1:0] i_dj,
    input  logic signed [PROD_W-1:0] i_dk,
    output logic signed [RI_W-1:0]   o_ri,
    output logic signed [RI_W-1:0]   o_rj,
    output logic signed [RI_W-1:0]   o_rk,
    output logic [RES_W-1:0]         o_ai,
    output logic [RES_W-1:0]         o_aj,
    output logic [RES_W-1:0]         o_ak
);

    logic signed [RI_W-1:0] n_ri, n_rj, n_rk;
    logic [RES_W-1:0]       n_ai, n_aj, n_ak;
    logic signed [RI_W-1:0] r_ri, r_rj, r_rk;
    logic [RES_W-1:0]       r_ai, r_aj, r_ak;

    function automatic logic [RI_W+RES_W-1:0] round_axis(input logic signed [PROD_W-1:0] d);
        logic [PROD_W-1:0]    mag;
        logic [RES_W-1:0]     frac;
        logic [RI_W-1:0]      r;
        logic [RES_W-1:0]     res;
        logic                 up;
        mag  = d[PROD_W-1] ? PROD_W'(-d) : PROD_W'(d);
        frac = mag[FRAC_BITS-1:0];
        up   = frac[FRAC_BITS-1];
        r    = RI_W'(mag[PROD_W-1:FRAC_BITS]) + RI_W'(up);
        res  = up ? RES_W'(-frac) : frac;
        if (d[PROD_W-1]) begin
            r = -r;
        end
        return {r, res};
    endfunction

    always_comb begin
        {n_ri, n_ai} = round_axis(i_di);
        {n_rj, n_aj} = round_axis(i_dj);
        {n_rk, n_ak} = round_axis(i_dk);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ri <= n_ri;
            r_rj <= n_rj;
            r_rk <= n_rk;
            r_ai <= n_ai;
            r_aj <= n_aj;
            r_ak <= n_ak;
        end
    end

    assign o_ri = r_ri;
    assign o_rj = r_rj;
    assign o_rk = r_rk;
    assign o_ai = r_ai;
    assign o_aj = r_aj;
    assign o_ak = r_ak;

endmodule

// ===== hdl/phx_fix.sv =====
// ----------------------------------------------------------------------------
// phx_fix
// Two stages: pick the axis that takes the sum correction, then correct
// and clamp to the index range.
// ----------------------------------------------------------------------------
module phx_fix
    import phx_pkg::*;
(
    input  logic                          i_clk,
    input  logic [1:0]                    i_adv,
    input  logic signed [RI_W-1:0]        i_ri,
    input  logic signed [RI_W-1:0]        i_rj,
    input  logic signed [RI_W-1:0]        i_rk,
    input  logic [RES_W-1:0]              i_ai,
    input  logic [RES_W-1:0]              i_aj,
    input  logic [RES_W-1:0]              i_ak,
    output logic signed [INDEX_WIDTH-1:0] o_cell_i,
    output logic signed [INDEX_WIDTH-1:0] o_cell_j,
    output logic signed [INDEX_WIDTH-1:0] o_cell_k,
    output logic                          o_sat
);

    localparam logic signed [COR_W-1:0] IDX_HI = COR_W'((1 << (INDEX_WIDTH - 1)) - 1);
    localparam logic signed [COR_W-1:0] IDX_LO = -COR_W'(1 << (INDEX_WIDTH - 1));

    logic signed [RI_W-1:0]        r_ri, r_rj, r_rk;
    logic signed [SUM_W-1:0]       r_sum;
    logic [1:0]                    r_axis;
    logic [1:0]                    n_axis;
    logic signed [COR_W-1:0]       ci, cj, ck;
    logic signed [INDEX_WIDTH-1:0] n_i, n_j, n_k;
    logic                          sat_i, sat_j, sat_k;
    logic signed [INDEX_WIDTH-1:0] r_cell_i, r_cell_j, r_cell_k;
    logic                          r_sat;

    function automatic logic [INDEX_WIDTH:0] clamp(input logic signed [COR_W-1:0] v);
        logic signed [COR_W-1:0] c;
        logic                    s;
        c = v;
        s = 1'b0;
        if (v > IDX_HI) begin
            c = IDX_HI;
            s = 1'b1;
        end
        if (v < IDX_LO) begin
            c = IDX_LO;
            s = 1'b1;
        end
        return {s, c[INDEX_WIDTH-1:0]};
    endfunction

    always_comb begin
        priority if (i_ai >= i_aj && i_ai >= i_ak) begin
            n_axis = AX_I;
        end else if (i_aj >= i_ai && i_aj >= i_ak) begin
            n_axis = AX_J;
        end else begin
            n_axis = AX_K;
        end
    end

    always_comb begin
        ci = COR_W'(r_ri);
        cj = COR_W'(r_rj);
        ck = COR_W'(r_rk);
        unique case (r_axis)
            AX_I: begin
                ci = COR_W'(r_ri) - COR_W'(r_sum);
            end
            AX_J: begin
                cj = COR_W'(r_rj) - COR_W'(r_sum);
            end
            default: begin
                ck = COR_W'(r_rk) - COR_W'(r_sum);
            end
        endcase
        {sat_i, n_i} = clamp(ci);
        {sat_j, n_j} = clamp(cj);
        {sat_k, n_k} = clamp(ck);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_ri   <= i_ri;
            r_rj   <= i_rj;
            r_rk   <= i_rk;
            r_sum  <= SUM_W'(i_ri) + SUM_W'(i_rj) + SUM_W'(i_rk);
            r_axis <= n_axis;
        end
        if (i_adv[1]) begin
            r_cell_i <= n_i;
            r_cell_j <= n_j;
            r_cell_k <= n_k;
            r_sat    <= sat_i | sat_j | sat_k;
        end
    end

    assign o_cell_i = r_cell_i;
    assign o_cell_j = r_cell_j;
    assign o_cell_k = r_cell_k;
    assign o_sat    = r_sat;

endmodule

// ===== tb/tb_point_to_hex_cell_quantizer_top.sv =====
// ----------------------------------------------------------------------------
// tb_point_to_hex_cell_quantizer_top
// Self-checking bench for the point to hex cell quantizer.
//
// Points go in over the slave stream. An in-bench predictor computes the
// expected cube cell for each transfer: the rotated projections, rounding
// half away from zero, the largest-residual correction and clamping. Results
// from the master stream are checked in order. The run covers a directed set
// of extreme and tie points, random points under several idle and stall mixes
// with several unit settings, and a long output hold-off that fills the
// pipeline and stalls its input.
// ----------------------------------------------------------------------------
module tb_point_to_hex_cell_quantizer_top;
    import phx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_REPORTS    = 40;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [INDEX_WIDTH-1:0] t_index;
    typedef logic [UNIT_WIDTH-1:0]         t_unit;

    typedef struct packed {
        t_index cell_i;
        t_index cell_j;
        t_index cell_k;
        logic   sat;
    } t_cell;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [2*COORD_WIDTH-1:0]  s_axis_tdata;   // point_x, point_y
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [3*INDEX_WIDTH-1:0]  m_axis_tdata;   // cell_i, cell_j, cell_k
    logic                      m_axis_tuser;   // index_saturated
    logic                      i_cfg_we;
    logic [UNIT_WIDTH-1:0]     i_cfg_wdata;

    t_cell cell_expect_q[$];
    t_unit unit_mirror = UNIT_RESET;

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    logic hold_active = 1'b0;
    event hold_kick;

    int mismatch_count = 0;
    int points_sent    = 0;
    int cells_checked  = 0;
    int cells_clamped  = 0;
    int unit_writes    = 0;
    int idle_cycles    = 0;

    point_to_hex_cell_quantizer_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint round_away(input longint d, output longint unsigned resid);
        longint unsigned mag;
        longint unsigned r;
        longint unsigned rs;
        if (d < 0) begin
            mag = longint'(-d);
        end else begin
            mag = d;
        end
        r = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        rs = r << FRAC_BITS;
        resid = (rs >= mag) ? rs - mag : mag - rs;
        return (d < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic t_index clamp_index(input longint v, inout logic sat);
        longint hi;
        longint lo;
        hi = (longint'(1) << (INDEX_WIDTH - 1)) - 1;
        lo = -(longint'(1) << (INDEX_WIDTH - 1));
        if (v > hi) begin
            v = hi;
            sat = 1'b1;
        end
        if (v < lo) begin
            v = lo;
            sat = 1'b1;
        end
        return t_index'(v);
    endfunction

    function automatic t_cell predict_cell(input t_coord px, input t_coord py, input t_unit unit);
        longint x, y, u;
        longint proj_i, proj_j, proj_k;
        longint rnd_i, rnd_j, rnd_k, total;
        longint unsigned res_i, res_j, res_k;
        logic sat;
        t_cell c;
        x = px;
        y = py;
        u = longint'(unit);
        proj_i = x * COS30_Q14 + y * (longint'(1) << HALF_SHIFT);
        proj_j = -x * COS30_Q14 + y * (longint'(1) << HALF_SHIFT);
        proj_k = -y * (longint'(1) << ONE_SHIFT);
        rnd_i = round_away(proj_i * u, res_i);
        rnd_j = round_away(proj_j * u, res_j);
        rnd_k = round_away(proj_k * u, res_k);
        total = rnd_i + rnd_j + rnd_k;
        if (total != 0) begin
            if (res_i >= res_j && res_i >= res_k) begin
                rnd_i = rnd_i - total;
            end else if (res_j >= res_i && res_j >= res_k) begin
                rnd_j = rnd_j - total;
            end else begin
                rnd_k = rnd_k - total;
            end
        end
        sat = 1'b0;
        c.cell_i = clamp_index(rnd_i, sat);
        c.cell_j = clamp_index(rnd_j, sat);
        c.cell_k = clamp_index(rnd_k, sat);
        c.sat = sat;
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver side: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_active) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always begin
        @(hold_kick);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        hold_active = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    task automatic report_field(input string name, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_cell got;
        t_cell want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.cell_i = m_axis_tdata[INDEX_WIDTH-1:0];
            got.cell_j = m_axis_tdata[2*INDEX_WIDTH-1:INDEX_WIDTH];
            got.cell_k = m_axis_tdata[3*INDEX_WIDTH-1:2*INDEX_WIDTH];
            got.sat    = m_axis_tuser;
            if (cell_expect_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, got (%0d,%0d,%0d) sat %0b",
                         $time, got.cell_i, got.cell_j, got.cell_k, got.sat);
            end else begin
                want = cell_expect_q.pop_front();
                cells_checked++;
                if (want.sat) cells_clamped++;
                if (got.cell_i != want.cell_i) report_field("cell_i", want.cell_i, got.cell_i);
                if (got.cell_j != want.cell_j) report_field("cell_j", want.cell_j, got.cell_j);
                if (got.cell_k != want.cell_k) report_field("cell_k", want.cell_k, got.cell_k);
                if (got.sat != want.sat) report_field("index_saturated", want.sat, got.sat);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles without any transfer
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, cell_expect_q.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    task automatic send_point(input t_coord px, input t_coord py);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {py, px};
        do @(posedge i_clk); while (!s_axis_tready);
        cell_expect_q.insert(cell_expect_q.size(), predict_cell(px, py, unit_mirror));
        points_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (cell_expect_q.size() != 0) @(negedge i_clk);
        repeat (N_STAGES + 3) @(negedge i_clk);
    endtask

    task automatic write_unit(input t_unit value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        unit_mirror = value;
        unit_writes++;
    endtask

    function automatic t_coord rand_coord();
        int unsigned pick;
        int v;
        pick = $urandom_range(99);
        if (pick < 40) begin
            v = int'($urandom);
        end else if (pick < 80) begin
            v = int'($urandom_range(8191)) - 4096;
        end else begin
            // multiples of half a unit can land on rounding ties
            v = (int'($urandom_range(63)) - 32) * 128;
        end
        return t_coord'(v);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        // reset unit of 1.0
        send_point(16'sd0, 16'sd0);
        send_point(16'sd32767, 16'sd32767);
        send_point(16'sh8000, 16'sh8000);
        send_point(16'sd32767, 16'sh8000);
        send_point(16'sh8000, 16'sd32767);
        send_point(16'sd0, 16'sd256);
        send_point(16'sd0, -16'sd256);
        send_point(16'sd256, 16'sd0);
        send_point(16'sd1, 16'sd0);
        send_point(-16'sd1, 16'sd0);
        send_point(16'sd0, 16'sd1);
        send_point(16'sd0, -16'sd1);
        send_point(16'sd32767, 16'sd0);
        send_point(16'sd0, 16'sh8000);
        wait_drained();
        write_unit('0);
        send_point(16'sd32767, 16'sd32767);
        send_point(16'sh8000, 16'sd1234);
        wait_drained();
        write_unit('1);
        send_point(16'sd256, 16'sd256);
        send_point(16'sh8000, 16'sh8000);
        send_point(16'sd1, 16'sd1);
        wait_drained();
        write_unit(t_unit'(1));
        send_point(16'sd32767, 16'sd32767);
        send_point(16'sh8000, 16'sh8000);
    endtask

    task automatic test_random_points(input int src_pct, input int snk_pct,
                                      input t_unit unit, input int count);
        wait_drained();
        write_unit(unit);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        repeat (count) send_point(rand_coord(), rand_coord());
    endtask

    task automatic test_output_hold();
        wait_drained();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        -> hold_kick;
        repeat (40) send_point(rand_coord(), rand_coord());
        // sender waits here until every result is back
        wait_drained();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_points(0, 0, UNIT_RESET, 100);
        test_random_points(0, 0, t_unit'($urandom), 100);
        test_random_points(64, 0, '1, 100);
        test_random_points(64, 0, t_unit'($urandom_range(16383, 1024)), 100);
        test_output_hold();
        test_random_points(0, 64, t_unit'($urandom), 100);
        test_random_points(0, 64, t_unit'(2048), 100);
        test_random_points(38, 38, t_unit'($urandom_range(8191, 256)), 100);
        test_random_points(38, 38, UNIT_RESET, 100);
        wait_drained();

        if (cell_expect_q.size() != 0) begin
            mismatch_count++;
            $display("%0t: %0d results never arrived", $time, cell_expect_q.size());
        end
        $display("Covered %0d points over %0d unit settings, %0d cells checked, %0d clamped.",
                 points_sent, unit_writes + 1, cells_checked, cells_clamped);
        $display("Idle/stall mixes 0/0, 64/0, 0/64, 38/38 and one %0d-cycle output hold.",
                 HOLD_CYCLES);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
